// ===== rtl/mvat_pkg.sv =====
// ----------------------------------------------------------------------------
// mvat_pkg
// Field widths and request codes of the mesh vertex adjacency table.
// ----------------------------------------------------------------------------
package mvat_pkg;

  localparam int KIND_W   = 2;
  localparam int VERT_W   = 12;
  localparam int FACE_W   = 14;
  localparam int CORNER_W = 2;
  localparam int EDGE_W   = FACE_W + CORNER_W;
  localparam int TOTAL_W  = 4;

  localparam logic [KIND_W-1:0] KIND_ADD_EDGE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE_FACES = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VERT_COUNT = 2'd2;

endpackage

// ===== rtl/mvat_ram.sv =====
// ----------------------------------------------------------------------------
// mvat_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mvat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mesh_vertex_adjacency_table_core.sv =====
// ----------------------------------------------------------------------------
// mesh_vertex_adjacency_table_core
// Per-vertex neighbor and face lists of a quad mesh, built one face edge at a
// time, with edge and vertex queries.
// ----------------------------------------------------------------------------
// Scans: an insert walks the neighbor and face lists of both endpoints, a
//   kind 1 query walks the neighbor list of vert_a only, and a count query
//   walks no list. The slot scans go through the one read port of each list
//   memory, one slot per cycle.
// Throughput: one item at a time; the next item enters once the result is
//   parked in the output register.
// Reset: synchronous; a clearing pass zeroes every word of the count memory,
//   and item_stall stays high until it ends.
// ----------------------------------------------------------------------------
module mesh_vertex_adjacency_table_core #(
  parameter int NUM_VERTS      = 4096,
  parameter int MAX_VALENCE    = 8,
  parameter int MAX_FACE_SLOTS = 8,
  parameter int NUM_FACES      = 16384
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [mvat_pkg::KIND_W-1:0]     kind,
  input  logic [mvat_pkg::VERT_W-1:0]     vert_a,
  input  logic [mvat_pkg::VERT_W-1:0]     vert_b,
  input  logic [mvat_pkg::FACE_W-1:0]     face_number,
  input  logic [mvat_pkg::CORNER_W-1:0]   corner,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            found,
  output logic                            overflow,
  output logic [mvat_pkg::FACE_W-1:0]     face_first,
  output logic [mvat_pkg::FACE_W-1:0]     face_second,
  output logic [mvat_pkg::TOTAL_W-1:0]    neighbor_total,
  output logic [mvat_pkg::TOTAL_W-1:0]    face_total
);

  import mvat_pkg::*;

  // vertex index, slot index and count widths
  localparam int VW  = (NUM_VERTS > 2) ? $clog2(NUM_VERTS) : 1;
  localparam int NSW = $clog2(MAX_VALENCE);
  localparam int FSW = $clog2(MAX_FACE_SLOTS);
  localparam int NCW = $clog2(MAX_VALENCE + 1);
  localparam int FCW = $clog2(MAX_FACE_SLOTS + 1);
  localparam int IW  = (NCW > FCW) ? NCW : FCW;
  localparam int CNT_W = NCW + FCW;
  localparam int NBR_DEPTH  = NUM_VERTS * (2 ** NSW);
  localparam int FACE_DEPTH = NUM_VERTS * (2 ** FSW);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CNT_RD, S_CNT_WAIT, S_NSCAN, S_NUPD,
    S_FSCAN, S_FUPD, S_CNT_WR, S_DONE
  } state_t;

  state_t state;

  // latched item
  logic [VW-1:0]       a_r, b_r;
  logic [FACE_W-1:0]   face_r;
  logic [CORNER_W-1:0] corner_r;
  logic                ins, qry, side_b;

  // working counts of the current endpoint
  logic [NCW-1:0] nc;
  logic [FCW-1:0] fc;

  // scan pipeline: idx issues the read, chk_* tracks the slot whose data is back
  logic [IW-1:0] idx, chk_idx;
  logic          chk_valid;
  logic          nhit;
  logic [NSW-1:0] hit_slot;
  logic          fhit;

  logic [VW-1:0] clr_addr;

  // result under construction
  logic               acc_found, acc_ovf;
  logic [FACE_W-1:0]  acc_f1, acc_f2;
  logic [TOTAL_W-1:0] acc_nt, acc_ft;

  // memory ports
  logic             cnt_we;
  logic [VW-1:0]    cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;

  logic                nbr_we, edge1_we, edge2_we;
  logic [VW+NSW-1:0]   nbr_waddr, nbr_raddr;
  logic [VW-1:0]       nbr_rdata;
  logic [EDGE_W-1:0]   edge1_rdata, edge2_rdata;

  logic                face_we;
  logic [VW+FSW-1:0]   face_waddr, face_raddr;
  logic [FACE_W-1:0]   face_rdata;

  logic [VW-1:0]     cur_v, other_v;
  logic [EDGE_W-1:0] eidx;
  logic              n_new, f_new;
  logic              a_ok, b_ok, f_ok;

  assign cur_v   = side_b ? b_r : a_r;
  assign other_v = side_b ? a_r : b_r;
  assign eidx    = {face_r, corner_r};

  // new-entry decisions, valid in the update states
  assign n_new = ins && !nhit && (nc < NCW'(MAX_VALENCE));
  assign f_new = !fhit && (fc < FCW'(MAX_FACE_SLOTS));

  assign a_ok = 32'(vert_a) < NUM_VERTS;
  assign b_ok = 32'(vert_b) < NUM_VERTS;
  assign f_ok = 32'(face_number) < NUM_FACES;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cnt_we    = (state == S_CLR) || (state == S_CNT_WR);
    cnt_waddr = (state == S_CLR) ? clr_addr : cur_v;
    cnt_wdata = (state == S_CLR) ? '0 : {nc, fc};

    nbr_raddr  = {cur_v, idx[NSW-1:0]};
    nbr_waddr  = nhit ? {cur_v, hit_slot} : {cur_v, nc[NSW-1:0]};
    nbr_we     = (state == S_NUPD) && n_new;
    edge1_we   = (state == S_NUPD) && n_new;
    edge2_we   = (state == S_NUPD) && ins && (nhit || n_new);

    face_raddr = {cur_v, idx[FSW-1:0]};
    face_waddr = {cur_v, fc[FSW-1:0]};
    face_we    = (state == S_FUPD) && f_new;
  end

  mvat_ram #(.WIDTH(CNT_W), .DEPTH(NUM_VERTS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cur_v), .rdata(cnt_rdata)
  );

  mvat_ram #(.WIDTH(VW), .DEPTH(NBR_DEPTH)) u_nbr_ram (
    .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(other_v),
    .raddr(nbr_raddr), .rdata(nbr_rdata)
  );

  mvat_ram #(.WIDTH(EDGE_W), .DEPTH(NBR_DEPTH)) u_edge1_ram (
    .clk(clk), .we(edge1_we), .waddr(nbr_waddr), .wdata(eidx),
    .raddr(nbr_raddr), .rdata(edge1_rdata)
  );

  mvat_ram #(.WIDTH(EDGE_W), .DEPTH(NBR_DEPTH)) u_edge2_ram (
    .clk(clk), .we(edge2_we), .waddr(nbr_waddr), .wdata(eidx),
    .raddr(nbr_raddr), .rdata(edge2_rdata)
  );

  mvat_ram #(.WIDTH(FACE_W), .DEPTH(FACE_DEPTH)) u_face_ram (
    .clk(clk), .we(face_we), .waddr(face_waddr), .wdata(face_r),
    .raddr(face_raddr), .rdata(face_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
      side_b       <= 1'b0;
      ins          <= 1'b0;
      qry          <= 1'b0;
      chk_valid    <= 1'b0;
    end else begin
      // drop the parked result once it is taken, unless a new one replaces it
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      case (state)
        // zero every count word, one per cycle
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == VW'(NUM_VERTS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item_valid) begin
            a_r       <= VW'(vert_a);
            b_r       <= VW'(vert_b);
            face_r    <= face_number;
            corner_r  <= corner;
            ins       <= (kind == KIND_ADD_EDGE) && a_ok && b_ok && f_ok;
            qry       <= (kind == KIND_EDGE_FACES) && a_ok && b_ok;
            side_b    <= 1'b0;
            acc_found <= 1'b0;
            acc_ovf   <= 1'b0;
            acc_f1    <= '0;
            acc_f2    <= '0;
            acc_nt    <= '0;
            acc_ft    <= '0;
            // an out-of-range vert_a answers all zeros
            state     <= a_ok ? S_CNT_RD : S_DONE;
          end
        end

        S_CNT_RD: begin
          state <= S_CNT_WAIT;
        end

        S_CNT_WAIT: begin
          nc        <= cnt_rdata[CNT_W-1:FCW];
          fc        <= cnt_rdata[FCW-1:0];
          idx       <= '0;
          chk_valid <= 1'b0;
          if (ins || qry) begin
            state <= S_NSCAN;
          end else begin
            acc_nt <= TOTAL_W'(cnt_rdata[CNT_W-1:FCW]);
            acc_ft <= TOTAL_W'(cnt_rdata[FCW-1:0]);
            state  <= S_DONE;
          end
        end

        // walk the neighbor slots; edge stores are read alongside
        S_NSCAN: begin
          if (chk_valid && (nbr_rdata == other_v)) begin
            nhit     <= 1'b1;
            hit_slot <= chk_idx[NSW-1:0];
            if (qry) begin
              acc_f1 <= edge1_rdata[EDGE_W-1:CORNER_W];
              acc_f2 <= edge2_rdata[EDGE_W-1:CORNER_W];
            end
            state <= S_NUPD;
          end else if (idx < IW'(nc)) begin
            chk_valid <= 1'b1;
            chk_idx   <= idx;
            idx       <= idx + 1'b1;
          end else if (chk_valid) begin
            chk_valid <= 1'b0;
          end else begin
            nhit  <= 1'b0;
            state <= S_NUPD;
          end
        end

        S_NUPD: begin
          idx       <= '0;
          chk_valid <= 1'b0;
          if (!side_b) begin
            acc_found <= nhit;
          end
          if (qry) begin
            acc_nt <= TOTAL_W'(nc);
            acc_ft <= TOTAL_W'(fc);
            state  <= S_DONE;
          end else begin
            if (n_new) begin
              nc <= nc + 1'b1;
            end else if (!nhit) begin
              acc_ovf <= 1'b1;
            end
            state <= S_FSCAN;
          end
        end

        // walk the face slots of the same endpoint
        S_FSCAN: begin
          if (chk_valid && (face_rdata == face_r)) begin
            fhit  <= 1'b1;
            state <= S_FUPD;
          end else if (idx < IW'(fc)) begin
            chk_valid <= 1'b1;
            chk_idx   <= idx;
            idx       <= idx + 1'b1;
          end else if (chk_valid) begin
            chk_valid <= 1'b0;
          end else begin
            fhit  <= 1'b0;
            state <= S_FUPD;
          end
        end

        S_FUPD: begin
          if (f_new) begin
            fc <= fc + 1'b1;
          end else if (!fhit) begin
            acc_ovf <= 1'b1;
          end
          state <= S_CNT_WR;
        end

        // write back the counts; a self edge reports the second pass
        S_CNT_WR: begin
          if (!side_b || (b_r == a_r)) begin
            acc_nt <= TOTAL_W'(nc);
            acc_ft <= TOTAL_W'(fc);
          end
          if (!side_b) begin
            side_b <= 1'b1;
            state  <= S_CNT_RD;
          end else begin
            state  <= S_DONE;
          end
        end

        // park the result once the output register is free
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid   <= 1'b1;
            found          <= acc_found;
            overflow       <= acc_ovf;
            face_first     <= acc_f1;
            face_second    <= acc_f2;
            neighbor_total <= acc_nt;
            face_total     <= acc_ft;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/mesh_vertex_adjacency_table_core_test.sv =====
// ----------------------------------------------------------------------------
// mesh_vertex_adjacency_table_core_test
// Self-checking bench for the mesh vertex adjacency table. Edge inserts,
// edge queries and count queries go in through the item channel. An in-bench
// copy of the neighbor and face lists predicts every result, and the checker
// compares each result field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module mesh_vertex_adjacency_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mvat_pkg::*;

  localparam int NVERT  = 4096;
  localparam int NVAL   = 8;
  localparam int NFSLOT = 8;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_OFF_LEN = 400;

  typedef struct packed {
    logic               found;
    logic               overflow;
    logic [FACE_W-1:0]  face_first;
    logic [FACE_W-1:0]  face_second;
    logic [TOTAL_W-1:0] neighbor_total;
    logic [TOTAL_W-1:0] face_total;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [KIND_W-1:0]   kind = KIND_ADD_EDGE;
  logic [VERT_W-1:0]   vert_a = '0;
  logic [VERT_W-1:0]   vert_b = '0;
  logic [FACE_W-1:0]   face_number = '0;
  logic [CORNER_W-1:0] corner = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic found, overflow;
  logic [FACE_W-1:0]  face_first, face_second;
  logic [TOTAL_W-1:0] neighbor_total, face_total;

  mesh_vertex_adjacency_table_core dut (
    .clk, .rst, .item_valid, .item_stall, .kind, .vert_a, .vert_b,
    .face_number, .corner, .result_valid, .result_stall, .found, .overflow,
    .face_first, .face_second, .neighbor_total, .face_total
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the adjacency lists kept by the bench.
  int unsigned          nb_cnt [NVERT];
  int unsigned          fc_cnt [NVERT];
  logic [VERT_W-1:0]    nb_vert [NVERT*NVAL];
  logic [EDGE_W-1:0]    first_edge [NVERT*NVAL];
  logic [EDGE_W-1:0]    latest_edge [NVERT*NVAL];
  logic [FACE_W-1:0]    face_list [NVERT*NFSLOT];

  answer_t pending_answers[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_off_req = 0;
  int      hold_off_ack = 0;
  int      hold_off_cycles = 0;
  int      cycle_count = 0;

  function automatic int slot_of(int v, int nb);
    for (int i = 0; i < nb_cnt[v] && i < NVAL; i++)
      if (nb_vert[v*NVAL+i] == nb) return i;
    return -1;
  endfunction

  // Insert nb into v's neighbor list; return 1 when the list was full.
  function automatic bit link_vertex(int v, int nb, logic [EDGE_W-1:0] eidx);
    int s;
    s = slot_of(v, nb);
    if (s >= 0) begin
      latest_edge[v*NVAL+s] = eidx;
      return 1'b0;
    end
    if (nb_cnt[v] >= NVAL) return 1'b1;
    nb_vert[v*NVAL+nb_cnt[v]] = VERT_W'(nb);
    first_edge[v*NVAL+nb_cnt[v]] = eidx;
    latest_edge[v*NVAL+nb_cnt[v]] = eidx;
    nb_cnt[v]++;
    return 1'b0;
  endfunction

  function automatic bit attach_face(int v, logic [FACE_W-1:0] f);
    for (int i = 0; i < fc_cnt[v] && i < NFSLOT; i++)
      if (face_list[v*NFSLOT+i] == f) return 1'b0;
    if (fc_cnt[v] >= NFSLOT) return 1'b1;
    face_list[v*NFSLOT+fc_cnt[v]] = f;
    fc_cnt[v]++;
    return 1'b0;
  endfunction

  // Apply one accepted item to the mirror and return the expected answer.
  function automatic answer_t adjacency_answer(logic [KIND_W-1:0] k, int a, int b,
                                               logic [FACE_W-1:0] f,
                                               logic [CORNER_W-1:0] c);
    answer_t r;
    bit drop;
    int s;
    r = '0;
    if (k == KIND_ADD_EDGE) begin
      r.found = (slot_of(a, b) >= 0);
      drop = link_vertex(a, b, {f, c});
      drop |= link_vertex(b, a, {f, c});
      drop |= attach_face(a, f);
      drop |= attach_face(b, f);
      r.overflow = drop;
    end else if (k == KIND_EDGE_FACES) begin
      s = slot_of(a, b);
      if (s >= 0) begin
        r.found = 1'b1;
        r.face_first  = first_edge[a*NVAL+s][EDGE_W-1:CORNER_W];
        r.face_second = latest_edge[a*NVAL+s][EDGE_W-1:CORNER_W];
      end
    end
    r.neighbor_total = nb_cnt[a][TOTAL_W-1:0];
    r.face_total = fc_cnt[a][TOTAL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Offer one item, idling first at random; valid stays high afterwards.
  task automatic send_item(logic [KIND_W-1:0] k, int a, int b, int f, int c);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    vert_a      <= VERT_W'(a);
    vert_b      <= VERT_W'(b);
    face_number <= FACE_W'(f);
    corner      <= CORNER_W'(c);
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_answers.push_back(adjacency_answer(k, a, b, FACE_W'(f), CORNER_W'(c)));
  endtask

  // Receiver side: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_off_ack != hold_off_req) begin
      hold_off_ack    <= hold_off_req;
      hold_off_cycles <= HOLD_OFF_LEN;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
    result_stall <= (hold_off_cycles > 1) || ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("extra result", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        if (found != want.found)
          report_mismatch("found", int'(found), int'(want.found));
        if (overflow != want.overflow)
          report_mismatch("overflow", int'(overflow), int'(want.overflow));
        if (face_first != want.face_first)
          report_mismatch("face_first", int'(face_first), int'(want.face_first));
        if (face_second != want.face_second)
          report_mismatch("face_second", int'(face_second), int'(want.face_second));
        if (neighbor_total != want.neighbor_total)
          report_mismatch("neighbor_total", int'(neighbor_total),
                          int'(want.neighbor_total));
        if (face_total != want.face_total)
          report_mismatch("face_total", int'(face_total), int'(want.face_total));
      end
    end
  end

  // Timeout guard; covers the post-reset clearing pass many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** mesh_vertex_adjacency_table_core: FAILED **");
      $finish;
    end
  end

  // Extremes, repeat edge, self edge, queries on empty lists, unused kind,
  // and both kinds of full list.
  task automatic test_directed();
    send_item(KIND_EDGE_FACES, 0, 4095, 0, 0);
    send_item(KIND_VERT_COUNT, 4095, 0, 0, 0);
    send_item(KIND_ADD_EDGE, 0, 4095, 16383, 3);
    send_item(KIND_ADD_EDGE, 0, 4095, 5, 1);
    send_item(KIND_EDGE_FACES, 0, 4095, 0, 0);
    send_item(KIND_EDGE_FACES, 4095, 0, 0, 0);
    send_item(KIND_ADD_EDGE, 100, 100, 77, 2);
    send_item(KIND_EDGE_FACES, 100, 100, 0, 0);
    send_item(KIND_UNUSED, 0, 4095, 16383, 3);
    send_item(KIND_VERT_COUNT, 0, 0, 0, 0);
    // Nine neighbors and nine faces on vertex 2000: last one overflows.
    for (int i = 0; i < 9; i++) send_item(KIND_ADD_EDGE, 2000, 2001 + i, 300 + i, i % 4);
    send_item(KIND_VERT_COUNT, 2000, 0, 0, 0);
    send_item(KIND_EDGE_FACES, 2000, 2009, 0, 0);
    // Known neighbor with a new face while the face list is full.
    send_item(KIND_ADD_EDGE, 2000, 2001, 999, 0);
    send_item(KIND_EDGE_FACES, 2000, 2001, 0, 0);
  endtask

  // Mostly quad faces over a small vertex pool so lists fill; some queries
  // and some full-range noise.
  task automatic test_random(int count);
    int pool_base, sent, quad[4], f, pick;
    pool_base = $urandom_range(NVERT - 12);
    sent = 0;
    while (sent < count) begin
      if (sent % 60 == 0) pool_base = $urandom_range(NVERT - 12);
      pick = $urandom_range(99);
      if (pick < 55) begin
        for (int i = 0; i < 4; i++) quad[i] = pool_base + $urandom_range(11);
        f = $urandom_range(16383);
        for (int i = 0; i < 4; i++) send_item(KIND_ADD_EDGE, quad[i], quad[(i+1)%4], f, i);
        sent += 4;
      end else if (pick < 85) begin
        send_item(KIND_EDGE_FACES, pool_base + $urandom_range(11),
                  pool_base + $urandom_range(11), $urandom_range(16383), $urandom_range(3));
        sent++;
      end else if (pick < 95) begin
        send_item(KIND_VERT_COUNT, pool_base + $urandom_range(11), $urandom_range(4095),
                  $urandom_range(16383), $urandom_range(3));
        sent++;
      end else begin
        send_item(KIND_W'($urandom_range(3)), $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(16383), $urandom_range(3));
        sent++;
      end
    end
  endtask

  // Hold the result side off while items keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req++;
    test_random(40);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 12;
    recv_idle_pct = 75;
    test_random(500);
    send_idle_pct = 75;
    recv_idle_pct = 12;
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);
    test_backpressure();
    item_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("** mesh_vertex_adjacency_table_core: PASSED **");
    end else begin
      $display("** mesh_vertex_adjacency_table_core: FAILED **");
    end
    $finish;
  end

endmodule
